FILE: hdl/ptq_pkg.sv
// Shared types and constants for the point table query block.
package ptq_pkg;

  localparam int MaxPoints = 64;
  localparam int CoordW = 24;
  localparam int IdW = 16;
  localparam int DistW = 52;

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_CLEAR   = 2'd1,
    ACT_NEAREST = 2'd2,
    ACT_RANGE   = 2'd3
  } action_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [1:0]               action;
    logic [IdW-1:0]           point_id;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic [CoordW-1:0]        range_limit;
  } ptq_in_t;

  typedef struct packed {
    logic [1:0]     status;
    logic [IdW-1:0] match_id;
    logic           last;
  } ptq_out_t;

  // One stored point as it moves through the chain.
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
  } point_t;

endpackage

FILE: hdl/ptq_if.sv
// Valid/ready channel interfaces for the point table query block.
interface ptq_in_if import ptq_pkg::*; ();
  logic    valid;
  logic    ready;
  ptq_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ptq_out_if import ptq_pkg::*; ();
  logic     valid;
  logic     ready;
  ptq_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/ptq_cell.sv
// One storage cell of the rotating point chain.
module ptq_cell import ptq_pkg::*; (
  input  logic   clk,
  input  logic   shift,
  input  point_t prev,
  output point_t pt
);

  always_ff @(posedge clk) begin
    if (shift) begin
      pt <= prev;
    end
  end

endmodule

FILE: hdl/ptq_dist.sv
// Pipelined squared distance: square per axis, then sum.
module ptq_dist import ptq_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [CoordW-1:0] qx,
  input  logic signed [CoordW-1:0] qy,
  input  logic signed [CoordW-1:0] qz,
  input  point_t                   pt,
  output logic [DistW-1:0]         dsq
);

  logic signed [CoordW:0] dx, dy, dz;
  logic [CoordW-1:0]      ax, ay, az;
  logic [2*CoordW-1:0]    sx, sy, sz;

  always_comb begin
    dx = (CoordW+1)'($signed(pt.x)) - (CoordW+1)'(qx);
    dy = (CoordW+1)'($signed(pt.y)) - (CoordW+1)'(qy);
    dz = (CoordW+1)'($signed(pt.z)) - (CoordW+1)'(qz);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
      ay <= dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];
      az <= dz[CoordW] ? CoordW'(-dz) : dz[CoordW-1:0];
      sx <= ax * ax;
      sy <= ay * ay;
      sz <= az * az;
      dsq <= DistW'(sx) + DistW'(sy) + DistW'(sz);
    end
  end

endmodule

FILE: hdl/point_table_nearest_and_range_query.sv
// Point table query block: add, clear, nearest and range queries.
// Add and query items rotate all MAX_POINTS cells past a three-stage distance pipe, while a clear
// item skips the scan and goes straight to its result. One item is in work at a time and
// input reopens the cycle after the final result transfer; a stalled output freezes the scan
// until the result is taken. Synchronous reset empties the table and idles the controller;
// cell contents are kept.
module point_table_nearest_and_range_query import ptq_pkg::*; #(
  parameter int MAX_POINTS = MaxPoints
) (
  input logic clk,
  input logic rst,
  ptq_in_if.sink   in_ch,
  ptq_out_if.source out_ch
);

  localparam int CntW = $clog2(MAX_POINTS + 1);
  localparam int Lat = 3;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} state_t;

  state_t            state;
  ptq_in_t           req;
  logic [CntW-1:0]   count;
  logic [CntW-1:0]   step;
  logic [Lat-1:0]    vpipe;
  logic [IdW-1:0]    idpipe [Lat];
  logic              found, dup;
  logic [DistW-1:0]  best;
  logic [IdW-1:0]    best_id;
  logic [2*CoordW-1:0] r2;
  logic              shift, load, adv;
  logic              hit, emit_match, fire, add_ok;
  point_t            cells [MAX_POINTS];
  point_t            newpt;
  logic [DistW-1:0]  dsq;
  logic              pend_v;
  ptq_out_t          pend;

  // Shifting loads the new point at the head when adding, else the tail wraps.
  assign newpt = '{id: req.point_id, x: req.pos_x, y: req.pos_y, z: req.pos_z};

  genvar g;
  generate
    for (g = 0; g < MAX_POINTS; g++) begin : g_cell
      point_t prev;
      if (g == 0) begin : g_head
        assign prev = load ? newpt : cells[MAX_POINTS-1];
      end else begin : g_body
        assign prev = cells[g-1];
      end
      ptq_cell u_cell (.clk(clk), .shift(shift | load), .prev(prev), .pt(cells[g]));
    end
  endgenerate

  ptq_dist u_dist (.clk(clk), .en(adv), .qx(req.pos_x), .qy(req.pos_y), .qz(req.pos_z),
                   .pt(cells[MAX_POINTS-1]), .dsq(dsq));

  // The scan and the distance pipe hold still while a result waits on a stalled output.
  assign adv = !pend_v || out_ch.ready;

  // Every cell passes the tail once per add or query item; stored points are the last count of them,
  // oldest first.
  assign shift = (state == S_SCAN) && step != '0 && adv;

  assign hit        = vpipe[Lat-1] && adv;
  assign emit_match = hit && req.action == ACT_RANGE && dsq <= DistW'(r2) && found;
  assign fire       = (state == S_DONE) && !pend_v;
  assign add_ok     = !dup && count < CntW'(MAX_POINTS);

  assign in_ch.ready  = (state == S_IDLE) && !pend_v;
  assign out_ch.valid = pend_v;
  assign out_ch.data  = pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      pend_v <= 1'b0;
      load   <= 1'b0;
      vpipe  <= '0;
    end else begin
      load <= fire && req.action == ACT_ADD && add_ok;
      if (adv) begin
        vpipe[0]  <= shift && step <= count;
        idpipe[0] <= cells[MAX_POINTS-1].id;
        for (int i = 1; i < Lat; i++) begin
          vpipe[i]  <= vpipe[i-1];
          idpipe[i] <= idpipe[i-1];
        end
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            req   <= in_ch.data;
            r2    <= in_ch.data.range_limit * in_ch.data.range_limit;
            step  <= CntW'(MAX_POINTS);
            state <= (in_ch.data.action == ACT_CLEAR) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (step == '0) state <= S_DRAIN;
          else if (shift) step <= step - 1'b1;
        end
        S_DRAIN: begin
          if (vpipe == '0) state <= S_DONE;
        end
        S_DONE: begin
          if (!pend_v) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      // Evaluate each point as its distance leaves the pipe.
      if (in_ch.valid && in_ch.ready) begin
        found <= 1'b0;
        dup   <= 1'b0;
      end else if (hit) begin
        case (req.action)
          ACT_ADD: if (idpipe[Lat-1] == req.point_id) dup <= 1'b1;
          ACT_NEAREST: if (!found || dsq < best) begin
            found <= 1'b1; best <= dsq; best_id <= idpipe[Lat-1];
          end
          ACT_RANGE: if (dsq <= DistW'(r2)) begin
            found <= 1'b1; best_id <= idpipe[Lat-1];
          end
          default: ;
        endcase
      end
      if (fire && req.action == ACT_CLEAR) count <= '0;
      else if (fire && req.action == ACT_ADD && add_ok) count <= count + 1'b1;
      // Hold back one match so the final one can carry last.
      if (emit_match) begin
        pend_v <= 1'b1;
        pend   <= '{status: ST_OK, match_id: best_id, last: 1'b0};
      end else if (fire) begin
        pend_v <= 1'b1;
        case (req.action)
          ACT_ADD: begin
            if (dup) pend <= '{status: ST_DUP, match_id: '0, last: 1'b1};
            else if (!add_ok) pend <= '{status: ST_FULL, match_id: '0, last: 1'b1};
            else pend <= '{status: ST_OK, match_id: '0, last: 1'b1};
          end
          ACT_CLEAR: begin
            pend <= '{status: ST_OK, match_id: '0, last: 1'b1};
          end
          default: begin
            if (found) pend <= '{status: ST_OK, match_id: best_id, last: 1'b1};
            else pend <= '{status: ST_NONE, match_id: '0, last: 1'b1};
          end
        endcase
      end else if (out_ch.valid && out_ch.ready) begin
        pend_v <= 1'b0;
      end
    end
  end

endmodule

FILE: tb/testbench.sv
// Testbench for the point table query block: queued driver that predicts results, checking monitor.
module testbench;
  import ptq_pkg::*;

  logic clk = 0;
  logic rst = 1;
  always #1 clk = ~clk;

  ptq_in_if in_ch ();
  ptq_out_if out_ch ();

  point_table_nearest_and_range_query DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Model of the table.
  logic [IdW-1:0]           tbl_id [MaxPoints];
  logic signed [CoordW-1:0] tbl_x [MaxPoints];
  logic signed [CoordW-1:0] tbl_y [MaxPoints];
  logic signed [CoordW-1:0] tbl_z [MaxPoints];
  int tbl_count = 0;

  ptq_in_t  pending_items [$];
  ptq_out_t awaited_results [$];
  int errors = 0;
  int cycle = 0;
  bit stim_done = 0;
  int hold_cycles = 0;
  int in_gap = 0;
  int out_gap = 0;

  task automatic report(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle, msg);
    errors++;
  endtask

  function automatic logic [DistW-1:0] dist_to(input int i, input ptq_in_t q);
    logic signed [CoordW:0] dx, dy, dz;
    dx = tbl_x[i] - q.pos_x;
    dy = tbl_y[i] - q.pos_y;
    dz = tbl_z[i] - q.pos_z;
    return DistW'(dx) * DistW'(dx) + DistW'(dy) * DistW'(dy) + DistW'(dz) * DistW'(dz);
  endfunction

  function automatic ptq_out_t mk(input logic [1:0] st, input logic [IdW-1:0] id,
                                  input logic lst);
    ptq_out_t r;
    r.status = st;
    r.match_id = id;
    r.last = lst;
    return r;
  endfunction

  task automatic predict_item(input ptq_in_t it);
    logic [DistW-1:0] best, d, r2;
    int best_i, hits;
    case (it.action)
      ACT_ADD: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_id[i] == it.point_id) begin
            awaited_results.push_back(mk(ST_DUP, 0, 1));
            return;
          end
        end
        if (tbl_count >= MaxPoints) begin
          awaited_results.push_back(mk(ST_FULL, 0, 1));
        end else begin
          tbl_id[tbl_count] = it.point_id;
          tbl_x[tbl_count] = it.pos_x;
          tbl_y[tbl_count] = it.pos_y;
          tbl_z[tbl_count] = it.pos_z;
          tbl_count++;
          awaited_results.push_back(mk(ST_OK, 0, 1));
        end
      end
      ACT_CLEAR: begin
        tbl_count = 0;
        awaited_results.push_back(mk(ST_OK, 0, 1));
      end
      ACT_NEAREST: begin
        best_i = -1;
        best = '0;
        for (int i = 0; i < tbl_count; i++) begin
          d = dist_to(i, it);
          if (best_i < 0 || d < best) begin
            best_i = i;
            best = d;
          end
        end
        if (best_i < 0) awaited_results.push_back(mk(ST_NONE, 0, 1));
        else awaited_results.push_back(mk(ST_OK, tbl_id[best_i], 1));
      end
      default: begin
        r2 = DistW'(it.range_limit) * DistW'(it.range_limit);
        hits = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (dist_to(i, it) <= r2) begin
            awaited_results.push_back(mk(ST_OK, tbl_id[i], 0));
            hits++;
          end
        end
        if (hits == 0) awaited_results.push_back(mk(ST_NONE, 0, 1));
        else awaited_results[$].last = 1;
      end
    endcase
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_item(in_ch.data);
        void'(pending_items.pop_front());
      end
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 0;
      end else if (pending_items.size() > (in_ch.valid && in_ch.ready ? 0 : 0)) begin
        in_ch.valid <= 1;
        in_ch.data <= pending_items[0];
        in_gap <= pick_gap();
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // Monitor and receiver stalls.
  always @(posedge clk) begin
    ptq_out_t exp_r;
    cycle <= cycle + 1;
    if (rst) begin
      out_ch.ready <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          report("result with nothing expected");
        end else begin
          exp_r = awaited_results.pop_front();
          if (out_ch.data.status !== exp_r.status)
            report($sformatf("status %0d, expected %0d", out_ch.data.status, exp_r.status));
          if (out_ch.data.match_id !== exp_r.match_id)
            report($sformatf("match_id %0d, expected %0d", out_ch.data.match_id,
                             exp_r.match_id));
          if (out_ch.data.last !== exp_r.last)
            report($sformatf("last %0d, expected %0d", out_ch.data.last, exp_r.last));
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ch.ready <= 0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
        out_gap <= (cycle > 3000 && cycle < 20000) ? 0 : pick_gap();
      end
      if (cycle == 1500) hold_cycles <= 800;
    end
    if (cycle > 2000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic signed [CoordW-1:0] rand_coord(input bit near);
    int k;
    if (near) return CoordW'($signed($urandom_range(0, 400)) - 200);
    k = $urandom_range(0, 5);
    if (k == 0) return 24'sh7FFFFF;
    if (k == 1) return 24'sh800000;
    return CoordW'($urandom);
  endfunction

  function automatic ptq_in_t rand_item(input bit near);
    ptq_in_t it;
    int a;
    a = $urandom_range(0, 99);
    it.action = a < 45 ? ACT_ADD : a < 48 ? ACT_CLEAR : a < 72 ? ACT_NEAREST : ACT_RANGE;
    it.point_id = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 15)) : 16'($urandom);
    it.pos_x = rand_coord(near);
    it.pos_y = rand_coord(near);
    it.pos_z = rand_coord(near);
    it.range_limit = near ? 24'($urandom_range(0, 300)) :
                     ($urandom_range(0, 3) == 0 ? 24'hFFFFFF : 24'($urandom));
    return it;
  endfunction

  function automatic ptq_in_t item(input action_t a, input logic [15:0] id,
                                   input int x, input int y, input int z, input int r);
    ptq_in_t it;
    it.action = a;
    it.point_id = id;
    it.pos_x = CoordW'(x);
    it.pos_y = CoordW'(y);
    it.pos_z = CoordW'(z);
    it.range_limit = CoordW'(r);
    return it;
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    // Directed: empty queries, extremes, duplicates, ties, a full table.
    pending_items.push_back(item(ACT_NEAREST, 0, 0, 0, 0, 0));
    pending_items.push_back(item(ACT_RANGE, 0, 0, 0, 0, 24'hFFFFFF));
    pending_items.push_back(item(ACT_ADD, 16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0));
    pending_items.push_back(item(ACT_ADD, 16'h0000, 24'h800000, 24'h800000, 24'h800000, 0));
    pending_items.push_back(item(ACT_ADD, 16'hFFFF, 1, 2, 3, 0));
    pending_items.push_back(item(ACT_NEAREST, 0, 0, 0, 0, 0));
    pending_items.push_back(item(ACT_RANGE, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0));
    pending_items.push_back(item(ACT_RANGE, 0, 0, 0, 0, 24'hFFFFFF));
    pending_items.push_back(item(ACT_RANGE, 0, 24'h800000, 24'h7FFFFF, 0, 24'hFFFFFF));
    pending_items.push_back(item(ACT_CLEAR, 0, 0, 0, 0, 0));
    pending_items.push_back(item(ACT_ADD, 5, 10, 0, 0, 0));
    pending_items.push_back(item(ACT_ADD, 6, -10, 0, 0, 0));
    pending_items.push_back(item(ACT_NEAREST, 0, 0, 0, 0, 0));
    pending_items.push_back(item(ACT_RANGE, 0, 0, 0, 0, 9));
    pending_items.push_back(item(ACT_RANGE, 0, 0, 0, 0, 10));
    for (int i = 0; i < 64; i++)
      pending_items.push_back(item(ACT_ADD, 16'(100 + i), i * 3, -i, i, 0));
    pending_items.push_back(item(ACT_ADD, 16'h1234, 0, 0, 0, 0));
    pending_items.push_back(item(ACT_ADD, 16'd100, 0, 0, 0, 0));
    pending_items.push_back(item(ACT_RANGE, 0, 0, 0, 0, 24'hFFFFFF));
    pending_items.push_back(item(ACT_NEAREST, 0, 30, -10, 10, 0));
    pending_items.push_back(item(ACT_CLEAR, 0, 0, 0, 0, 0));
    // Random: mostly clustered points so range queries match, some wide noise.
    for (int i = 0; i < 276; i++)
      pending_items.push_back(rand_item($urandom_range(0, 3) != 0));
    wait (pending_items.size() == 0);
    wait (awaited_results.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

FILE: point_table_nearest_and_range_query.f
hdl/ptq_pkg.sv
hdl/ptq_if.sv
hdl/ptq_cell.sv
hdl/ptq_dist.sv
hdl/point_table_nearest_and_range_query.sv
tb/testbench.sv
